// File: sv/clamp_point_to_circle_assert.svh
// assertion macros for the clamp point to circle block
`ifndef CLAMP_POINT_TO_CIRCLE_ASSERT_SVH
`define CLAMP_POINT_TO_CIRCLE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define CPC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("cpc assertion failed");

// antecedent implies consequent a fixed number of cycles later
`define CPC_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("cpc latency assertion failed");

// consequent implies antecedent held a fixed number of cycles earlier
`define CPC_ASSERT_PAST(lbl, cons, n, ante) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cons) |-> $past((ante), n)) \
    else $error("cpc origin assertion failed");

`endif

// File: sv/cpc_pkg.sv
`timescale 1ns / 1ps

package cpc_pkg;

  // field widths
  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 13;
  localparam int CENTER_BITS = 14;

  // difference and magnitude widths
  localparam int DIFF_W = ((COORD_BITS > CENTER_BITS + 1) ? COORD_BITS : CENTER_BITS + 1) + 1;
  localparam int MAG_W  = DIFF_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int DIST_W = SQ_W + 1;
  localparam int LIM2_W = 2 * RADIUS_BITS;
  localparam int ML_W   = MAG_W + RADIUS_BITS;
  localparam int HALF_W = (ML_W + 1) / 2;
  localparam int HI_W   = ML_W - HALF_W;
  localparam int RHS_W  = 2 * ML_W;
  localparam int P_W    = DIST_W + 2 * RADIUS_BITS;
  localparam int Q_W    = DIST_W + RADIUS_BITS;

  // start accept edge to result accept edge, in cycles
  localparam int LATENCY = RADIUS_BITS + 5;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTER = 1'b0,
    CFG_INNER = 1'b1
  } cfg_reg_e;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [CENTER_BITS-1:0]       cx;
    logic [CENTER_BITS-1:0]       cy;
    logic                         neg_x;
    logic                         neg_y;
    logic [MAG_W-1:0]             ax;
    logic [MAG_W-1:0]             ay;
  } item_t;

  // queue status toward the front
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: sv/cpc_front.sv
`timescale 1ns / 1ps

module cpc_front import cpc_pkg::*; (
  input  logic                         start,
  input  queue_stat_t                  qstat_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic [CENTER_BITS-1:0]       center_x_i,
  input  logic [CENTER_BITS-1:0]       center_y_i,
  output logic                         busy,
  output logic                         push_o,
  output item_t                        item_o
);

  logic signed [DIFF_W-1:0] dx, dy;

  // accept when the queue has room
  assign busy   = qstat_i.full;
  assign push_o = start & ~qstat_i.full;

  // offsets from the center
  assign dx = DIFF_W'(point_x_i) - $signed({{(DIFF_W-CENTER_BITS){1'b0}}, center_x_i});
  assign dy = DIFF_W'(point_y_i) - $signed({{(DIFF_W-CENTER_BITS){1'b0}}, center_y_i});

  // sign and magnitude
  always_comb begin
    item_o.px    = point_x_i;
    item_o.py    = point_y_i;
    item_o.cx    = center_x_i;
    item_o.cy    = center_y_i;
    item_o.neg_x = dx[DIFF_W-1];
    item_o.neg_y = dy[DIFF_W-1];
    item_o.ax    = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    item_o.ay    = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  end

endmodule

// File: sv/cpc_queue.sv
`timescale 1ns / 1ps

module cpc_queue import cpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  item_t       item_i,
  input  logic        pop_i,
  output queue_stat_t stat_o,
  output item_t       head_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign do_pop       = pop_i & (cnt_q != '0);
  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

// File: sv/cpc_back.sv
`timescale 1ns / 1ps

module cpc_back import cpc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  item_t                        item_i,
  input  logic [RADIUS_BITS-1:0]       lim_i,
  output logic                         out_valid_o,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o
);

  // fields carried down the pipe
  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [CENTER_BITS-1:0]       cx;
    logic [CENTER_BITS-1:0]       cy;
    logic                         neg_x;
    logic                         neg_y;
  } carry_t;

  // per step state of the root search
  typedef struct packed {
    carry_t                 c;
    logic                   in_disc;
    logic [DIST_W-1:0]      dist2;
    logic [RHS_W-1:0]       rhs_x;
    logic [RHS_W-1:0]       rhs_y;
    logic [P_W-1:0]         p_x;
    logic [P_W-1:0]         p_y;
    logic [Q_W-1:0]         s_x;
    logic [Q_W-1:0]         s_y;
    logic [RADIUS_BITS-1:0] q_x;
    logic [RADIUS_BITS-1:0] q_y;
  } step_t;

  carry_t c1_q, c2_q;
  logic   v1_q, v2_q;

  logic [SQ_W-1:0]   ax2_q, ay2_q;
  logic [ML_W-1:0]   mx_q, my_q;
  logic [LIM2_W-1:0] lim2_1_q, lim2_2_q;

  logic [DIST_W-1:0] dist2_q;
  logic [2*HI_W-1:0] hh_x_q, hh_y_q;
  logic [ML_W-1:0]   hl_x_q, hl_y_q;
  logic [2*HALF_W-1:0] ll_x_q, ll_y_q;

  logic  sv_q [RADIUS_BITS+1];
  step_t st_q [RADIUS_BITS+1];

  logic                         ov_q;
  logic signed [COORD_BITS-1:0] ox_q, oy_q;

  // valid bits along the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      sv_q[0]  <= 1'b0;
    end else begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      sv_q[0]  <= v2_q;
    end
  end

  // squares and scaled magnitudes
  always_ff @(posedge clk_i) begin
    c1_q.px    <= item_i.px;
    c1_q.py    <= item_i.py;
    c1_q.cx    <= item_i.cx;
    c1_q.cy    <= item_i.cy;
    c1_q.neg_x <= item_i.neg_x;
    c1_q.neg_y <= item_i.neg_y;
    ax2_q      <= SQ_W'(item_i.ax) * SQ_W'(item_i.ax);
    ay2_q      <= SQ_W'(item_i.ay) * SQ_W'(item_i.ay);
    mx_q       <= ML_W'(item_i.ax) * ML_W'(lim_i);
    my_q       <= ML_W'(item_i.ay) * ML_W'(lim_i);
    lim2_1_q   <= LIM2_W'(lim_i) * LIM2_W'(lim_i);
  end

  // distance and partial products of the right hand side
  always_ff @(posedge clk_i) begin
    c2_q     <= c1_q;
    lim2_2_q <= lim2_1_q;
    dist2_q  <= DIST_W'(ax2_q) + DIST_W'(ay2_q);
    hh_x_q   <= (2*HI_W)'(mx_q[ML_W-1:HALF_W]) * (2*HI_W)'(mx_q[ML_W-1:HALF_W]);
    hh_y_q   <= (2*HI_W)'(my_q[ML_W-1:HALF_W]) * (2*HI_W)'(my_q[ML_W-1:HALF_W]);
    hl_x_q   <= ML_W'(mx_q[ML_W-1:HALF_W]) * ML_W'(mx_q[HALF_W-1:0]);
    hl_y_q   <= ML_W'(my_q[ML_W-1:HALF_W]) * ML_W'(my_q[HALF_W-1:0]);
    ll_x_q   <= (2*HALF_W)'(mx_q[HALF_W-1:0]) * (2*HALF_W)'(mx_q[HALF_W-1:0]);
    ll_y_q   <= (2*HALF_W)'(my_q[HALF_W-1:0]) * (2*HALF_W)'(my_q[HALF_W-1:0]);
  end

  // sum partial products, disc test, clear search state
  always_ff @(posedge clk_i) begin
    st_q[0].c       <= c2_q;
    st_q[0].in_disc <= (dist2_q <= DIST_W'(lim2_2_q));
    st_q[0].dist2   <= dist2_q;
    st_q[0].rhs_x   <= (RHS_W'(hh_x_q) << (2*HALF_W)) + (RHS_W'(hl_x_q) << (HALF_W+1))
                       + RHS_W'(ll_x_q);
    st_q[0].rhs_y   <= (RHS_W'(hh_y_q) << (2*HALF_W)) + (RHS_W'(hl_y_q) << (HALF_W+1))
                       + RHS_W'(ll_y_q);
    st_q[0].p_x     <= '0;
    st_q[0].p_y     <= '0;
    st_q[0].s_x     <= '0;
    st_q[0].s_y     <= '0;
    st_q[0].q_x     <= '0;
    st_q[0].q_y     <= '0;
  end

  // one result bit per stage, msb first; p tracks q*q*dist2, s tracks q*dist2
  for (genvar k = 0; k < RADIUS_BITS; k++) begin : g_step
    localparam int B = RADIUS_BITS - 1 - k;
    logic [P_W-1:0] cand_x, cand_y;
    logic           take_x, take_y;
    step_t          step_d;

    assign cand_x = st_q[k].p_x + (P_W'(st_q[k].s_x) << (B + 1))
                    + (P_W'(st_q[k].dist2) << (2 * B));
    assign cand_y = st_q[k].p_y + (P_W'(st_q[k].s_y) << (B + 1))
                    + (P_W'(st_q[k].dist2) << (2 * B));
    assign take_x = (cand_x <= P_W'(st_q[k].rhs_x));
    assign take_y = (cand_y <= P_W'(st_q[k].rhs_y));

    // next stage state with the trial bit kept where it fits
    always_comb begin
      step_d = st_q[k];
      if (take_x) begin
        step_d.p_x = cand_x;
        step_d.s_x = st_q[k].s_x + (Q_W'(st_q[k].dist2) << B);
        step_d.q_x = st_q[k].q_x | (RADIUS_BITS'(1) << B);
      end
      if (take_y) begin
        step_d.p_y = cand_y;
        step_d.s_y = st_q[k].s_y + (Q_W'(st_q[k].dist2) << B);
        step_d.q_y = st_q[k].q_y | (RADIUS_BITS'(1) << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k+1] <= step_d;
    end
  end

  // signed offset from the center or pass through
  step_t                        fin;
  logic signed [COORD_BITS-1:0] off_x, off_y;
  assign fin   = st_q[RADIUS_BITS];
  assign off_x = fin.c.neg_x ? -COORD_BITS'(fin.q_x) : COORD_BITS'(fin.q_x);
  assign off_y = fin.c.neg_y ? -COORD_BITS'(fin.q_y) : COORD_BITS'(fin.q_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= sv_q[RADIUS_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q <= fin.in_disc ? fin.c.px : COORD_BITS'(fin.c.cx) + off_x;
    oy_q <= fin.in_disc ? fin.c.py : COORD_BITS'(fin.c.cy) + off_y;
  end

  assign out_valid_o = ov_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;

endmodule

// File: sv/clamp_point_to_circle.sv
`timescale 1ns / 1ps
// clamp_point_to_circle: limits a point to a disc of radius
// max(outer_radius - inner_radius, 0) around a given center.
// input: pulse start with point and center; the item is taken at a clock
//   edge where start is high and busy is low.
// config: cfg_valid_i / cfg_ready_o with cfg_index_i (0 outer, 1 inner)
//   and cfg_data_i; ready is always high. write only while idle.
// output: out_valid_o is high for one cycle with out_x_o / out_y_o; the
//   receiver cannot stall, so results are never held back.
// throughput: one item per cycle, set by the fully pipelined back end.
// path: an accepted item passes the queue register, the squares, partial
//   product and sum registers, the bit-per-stage root search and one
//   output register that holds the result beat.
// busy rises only if the two-entry queue fills, which the back end, draining
//   a beat each cycle, never lets happen.
// reset: clears the radius registers, the queue and all valid bits; items
//   in flight are dropped.
module clamp_point_to_circle import cpc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic [CENTER_BITS-1:0]       center_x_i,
  input  logic [CENTER_BITS-1:0]       center_y_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [RADIUS_BITS-1:0]       cfg_data_i,
  output logic                         out_valid_o,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o
);

`include "clamp_point_to_circle_assert.svh"

  logic [RADIUS_BITS-1:0] outer_q, inner_q, lim;
  logic                   push;
  item_t                  item, head;
  queue_stat_t            qstat;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= '0;
      inner_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_OUTER: outer_q <= cfg_data_i;
        CFG_INNER: inner_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // limit radius, zero when negative
  assign lim = (outer_q > inner_q) ? outer_q - inner_q : '0;

  cpc_front u_front (
    .start      (start),
    .qstat_i    (qstat),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .busy       (busy),
    .push_o     (push),
    .item_o     (item)
  );

  cpc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .pop_i  (1'b1),
    .stat_o (qstat),
    .head_o (head)
  );

  cpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (~qstat.empty),
    .item_i      (head),
    .lim_i       (lim),
    .out_valid_o (out_valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o)
  );

  // checks
  `CPC_ASSERT(a_queue_never_full, !busy)
  `CPC_ASSERT_DELAY(a_accept_gives_result, start && !busy, LATENCY, out_valid_o)
  `CPC_ASSERT_PAST(a_result_has_origin, out_valid_o, LATENCY, start && !busy)

endmodule
